@@ sv/slew_adaptive_poll_interval_defines.svh @@
// Assertion macros shared by the slew adaptive poll interval RTL.
`ifndef SLEW_ADAPTIVE_POLL_INTERVAL_DEFINES_SVH
`define SLEW_ADAPTIVE_POLL_INTERVAL_DEFINES_SVH

`ifndef SYNTHESIS
`define SAP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SAP_ASSERT_IMP(lbl, ante, cons, msg)
`define SAP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/sap_pkg.sv @@
// Package: types, widths and constants of the slew adaptive poll interval block.
package sap_pkg;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;
    localparam int unsigned MUL_AW = 24;
    localparam int unsigned MUL_BW = 20;
    localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
    localparam int unsigned DEN_W  = 24;

    localparam logic [23:0] SLEW_MAX  = 24'hFFFFFF;
    localparam logic [16:0] Q16_ONE   = 17'h10000;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam logic [23:0] RELAX_DEN = 24'd256000;

    typedef enum logic [2:0] {
        REG_NOMINAL = 3'd0,
        REG_FLOOR   = 3'd1,
        REG_START   = 3'd2,
        REG_FULL    = 3'd3,
        REG_RELAX   = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLEW_MUL,
        ST_SLEW_DIV,
        ST_LVL,
        ST_LVL_DIV,
        ST_SQ_MUL,
        ST_CUBE_MUL,
        ST_LVL_MUL,
        ST_TGT_MUL,
        ST_STEP,
        ST_RELAX_MUL,
        ST_RELAX_DIV,
        ST_DONE
    } t_state;

endpackage

@@ sv/sap_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module sap_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sap_pkg::MUL_AW-1:0]    i_a,
    input  logic [sap_pkg::MUL_BW-1:0]    i_b,
    output logic                          o_done,
    output logic [sap_pkg::MUL_PW-1:0]    o_prod
);
    import sap_pkg::*;

    localparam int unsigned CNT_W = $clog2(MUL_BW + 1);

    logic [MUL_PW-1:0] r_acc;
    logic [MUL_PW-1:0] r_a;
    logic [MUL_BW-1:0] r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MUL_BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= MUL_PW'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ sv/sap_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
module sap_div #(
    parameter int unsigned NUM_W = 56
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [sap_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [NUM_W-1:0]            o_quo
);
    import sap_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             qbit;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_num <= r_num << 1;
            r_quo <= {r_quo[NUM_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ sv/slew_adaptive_poll_interval.sv @@
// Top level: register port, sequencer and datapath of the adaptive poll interval block.
// With adaptation off the request goes straight to the output stage; otherwise it runs through
// the serial divider (up to four divisions) and the serial multiplier (up to seven products).
// Throughput: one request at a time; the next is taken once the result is in the output stage.
// Reset is synchronous, active low: registers return to defaults, history and interval cleared.
`include "slew_adaptive_poll_interval_defines.svh"

module slew_adaptive_poll_interval #(
    parameter int unsigned INTERVAL_FRAC_BITS = sap_pkg::FRAC_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] cpu_temp, [31:16] gpu_temp, [47:32] elapsed_ms
    input  logic [47:0] s_axis_tdata,
    // [0] cpu_present, [1] gpu_present
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] interval_ms, [32:16] transient_level, [39:33] zero
    output logic [39:0] m_axis_tdata
);
    import sap_pkg::*;

    localparam int unsigned F    = INTERVAL_FRAC_BITS;
    localparam int unsigned CW   = 16 + F;
    localparam int unsigned DW   = 40 + F;
    localparam logic [CW-1:0] SNAP = CW'((64'd1 << F) / 10000);
    localparam logic [CW:0]   HALF = (CW+1)'(1) << (F - 1);

    // configuration
    logic [15:0] r_nom, r_flo;
    logic [23:0] r_start, r_full, r_relax;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    // sequencer and datapath
    t_state      r_state, n_state;
    logic        r_go;
    logic [15:0] r_prev1, r_prev2;
    logic        r_pv1, r_pv2;
    logic [CW-1:0] r_cur;
    logic        r_ivalid;
    logic [15:0] r_el, r_mag1, r_mag2;
    logic        r_ok2, r_sens, r_dis;
    logic [23:0] r_slew;
    logic [15:0] r_a;
    logic [32:0] r_sq;
    logic [16:0] r_a2, r_a3, r_lvl;
    logic [19:0] r_qp;
    logic [15:0] r_tgt;
    logic [15:0] r_out_int;
    logic [16:0] r_out_lvl;
    logic        r_mvalid;

    logic              mul_go, mul_done, div_go, div_done;
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] mul_p;
    logic [DW-1:0]     div_num, div_quo;
    logic [DEN_W-1:0]  div_den;

    logic signed [16:0] d1, d2;
    logic [15:0] in_el;
    logic        in_ok1, in_ok2, dis, lvl_zero, imm;
    logic [23:0] slew_sat;
    logic [36:0] poly;
    logic [19:0] a15;
    logic [CW-1:0] nom_q, flo_q, tq, gap, stepped;
    logic [32:0] tgt_sum;
    logic [20:0] lvl_rnd;
    logic [CW:0] out_rnd;

    function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v,
                                            input logic [CW-1:0] lo,
                                            input logic [CW-1:0] hi);
        logic [CW-1:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nom   <= 16'd1000;
            r_flo   <= 16'd1000;
            r_start <= 24'd256;
            r_full  <= 24'd1280;
            r_relax <= 24'd25600;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_NOMINAL: r_nom   <= pwdata[15:0];
                REG_FLOOR:   r_flo   <= pwdata[15:0];
                REG_START:   r_start <= pwdata[23:0];
                REG_FULL:    r_full  <= pwdata[23:0];
                REG_RELAX:   r_relax <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_NOMINAL: prdata = {16'd0, r_nom};
            REG_FLOOR:   prdata = {16'd0, r_flo};
            REG_START:   prdata = {8'd0, r_start};
            REG_FULL:    prdata = {8'd0, r_full};
            REG_RELAX:   prdata = {8'd0, r_relax};
            default:     prdata = 32'd0;
        endcase
    end

    // request decode
    assign in_el  = s_axis_tdata[47:32];
    assign d1     = 17'(signed'(s_axis_tdata[15:0])) - 17'(signed'(r_prev1));
    assign d2     = 17'(signed'(s_axis_tdata[31:16])) - 17'(signed'(r_prev2));
    assign in_ok1 = s_axis_tuser[0] && r_pv1 && (in_el != 16'd0);
    assign in_ok2 = s_axis_tuser[1] && r_pv2 && (in_el != 16'd0);
    assign dis    = (r_flo >= r_nom);

    assign nom_q  = {r_nom, F'(0)};
    assign flo_q  = {r_flo, F'(0)};
    assign tq     = {r_tgt, F'(0)};
    assign gap    = tq - r_cur;
    assign stepped = ((gap <= SNAP) || (DW'(gap) <= div_quo)) ? tq
                                                              : r_cur + CW'(div_quo);

    assign lvl_zero = (r_el == 16'd0) || (r_full <= r_start) || (r_slew <= r_start);
    assign imm      = (r_el == 16'd0) || (tq <= r_cur) || (r_relax == 24'd0);
    assign slew_sat = (|div_quo[DW-1:24]) ? SLEW_MAX : div_quo[23:0];

    // 6a^2 + 10*2^32 - 15a*2^16
    assign a15  = {r_a, 4'd0} - {4'd0, r_a};
    assign poly = 37'({r_sq, 2'b0}) + 37'({r_sq, 1'b0}) + (37'(10) << 32)
                - {1'b0, a15, 16'd0};
    assign lvl_rnd = 21'((mul_p[36:0] + 37'd32768) >> 16);
    assign tgt_sum = {1'b0, r_nom, 16'd0} - 33'(mul_p[32:0]) + 33'd32768;
    assign out_rnd = {1'b0, r_cur} + HALF;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (dis)                   n_state = ST_DONE;
                    else if (in_ok1 || in_ok2) n_state = ST_SLEW_MUL;
                    else                       n_state = ST_LVL;
                end
            end
            ST_SLEW_MUL:  if (mul_done) n_state = ST_SLEW_DIV;
            ST_SLEW_DIV: begin
                if (div_done) n_state = (!r_sens && r_ok2) ? ST_SLEW_MUL : ST_LVL;
            end
            ST_LVL: begin
                if (lvl_zero || r_slew >= r_full) n_state = ST_TGT_MUL;
                else                              n_state = ST_LVL_DIV;
            end
            ST_LVL_DIV:   if (div_done) n_state = ST_SQ_MUL;
            ST_SQ_MUL:    if (mul_done) n_state = ST_CUBE_MUL;
            ST_CUBE_MUL:  if (mul_done) n_state = ST_LVL_MUL;
            ST_LVL_MUL:   if (mul_done) n_state = ST_TGT_MUL;
            ST_TGT_MUL:   if (mul_done) n_state = ST_STEP;
            ST_STEP:      n_state = imm ? ST_DONE : ST_RELAX_MUL;
            ST_RELAX_MUL: if (mul_done) n_state = ST_RELAX_DIV;
            ST_RELAX_DIV: if (div_done) n_state = ST_DONE;
            ST_DONE:      if (!r_mvalid || m_axis_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
        end
    end

    // unit operands follow the state; a unit starts on the first cycle of its state
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SLEW_MUL: begin
                mul_a = MUL_AW'(r_sens ? r_mag2 : r_mag1);
                mul_b = MUL_BW'(MS_PER_S);
            end
            ST_SQ_MUL: begin
                mul_a = MUL_AW'(r_a);
                mul_b = MUL_BW'(r_a);
            end
            ST_CUBE_MUL: begin
                mul_a = MUL_AW'(r_a2);
                mul_b = MUL_BW'(r_a);
            end
            ST_LVL_MUL: begin
                mul_a = MUL_AW'(r_qp);
                mul_b = MUL_BW'(r_a3);
            end
            ST_TGT_MUL: begin
                mul_a = MUL_AW'(r_nom - r_flo);
                mul_b = MUL_BW'(r_lvl);
            end
            ST_RELAX_MUL: begin
                mul_a = r_relax;
                mul_b = MUL_BW'(r_el);
            end
            default: ;
        endcase
    end

    always_comb begin
        div_num = '0;
        div_den = '0;
        case (r_state)
            ST_SLEW_DIV: begin
                div_num = DW'(mul_p[25:0]);
                div_den = DEN_W'(r_el);
            end
            ST_LVL_DIV: begin
                div_num = DW'({r_slew - r_start, 16'd0});
                div_den = r_full - r_start;
            end
            ST_RELAX_DIV: begin
                div_num = {mul_p[39:0], F'(0)};
                div_den = RELAX_DEN;
            end
            default: ;
        endcase
    end

    assign mul_go = r_go && (r_state == ST_SLEW_MUL || r_state == ST_SQ_MUL ||
                             r_state == ST_CUBE_MUL || r_state == ST_LVL_MUL ||
                             r_state == ST_TGT_MUL  || r_state == ST_RELAX_MUL);
    assign div_go = r_go && (r_state == ST_SLEW_DIV || r_state == ST_LVL_DIV ||
                             r_state == ST_RELAX_DIV);

    sap_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    sap_div #(.NUM_W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // history and working interval
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev1  <= '0;
            r_prev2  <= '0;
            r_pv1    <= 1'b0;
            r_pv2    <= 1'b0;
            r_cur    <= '0;
            r_ivalid <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && s_axis_tvalid && !dis) begin
                r_pv1   <= s_axis_tuser[0];
                r_pv2   <= s_axis_tuser[1];
                r_prev1 <= s_axis_tuser[0] ? s_axis_tdata[15:0] : 16'd0;
                r_prev2 <= s_axis_tuser[1] ? s_axis_tdata[31:16] : 16'd0;
                if (!r_ivalid) begin
                    r_cur    <= nom_q;
                    r_ivalid <= 1'b1;
                end
            end
            if (r_state == ST_STEP && imm) begin
                r_cur <= clamp(tq, flo_q, nom_q);
            end
            if (r_state == ST_RELAX_DIV && div_done) begin
                r_cur <= clamp(stepped, flo_q, nom_q);
            end
        end
    end

    // per-request working values
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_el   <= in_el;
                    r_mag1 <= d1[16] ? 16'(-d1) : d1[15:0];
                    r_mag2 <= d2[16] ? 16'(-d2) : d2[15:0];
                    r_ok2  <= in_ok2;
                    r_sens <= !in_ok1;
                    r_dis  <= dis;
                    r_slew <= '0;
                    r_lvl  <= '0;
                end
            end
            ST_SLEW_DIV: begin
                if (div_done) begin
                    if (slew_sat > r_slew) r_slew <= slew_sat;
                    r_sens <= 1'b1;
                end
            end
            ST_LVL: begin
                if (!lvl_zero && r_slew >= r_full) r_lvl <= Q16_ONE;
            end
            ST_LVL_DIV: if (div_done) r_a <= div_quo[15:0];
            ST_SQ_MUL: begin
                if (mul_done) begin
                    r_sq <= mul_p[32:0];
                    r_a2 <= 17'((34'(mul_p[32:0]) + 34'd32768) >> 16);
                end
            end
            ST_CUBE_MUL: begin
                if (mul_done) begin
                    r_a3 <= 17'((35'(mul_p[33:0]) + 35'd32768) >> 16);
                    r_qp <= 20'((poly + 37'd32768) >> 16);
                end
            end
            ST_LVL_MUL: begin
                if (mul_done) r_lvl <= (lvl_rnd > 21'(Q16_ONE)) ? Q16_ONE : lvl_rnd[16:0];
            end
            ST_TGT_MUL: if (mul_done) r_tgt <= tgt_sum[31:16];
            default: ;
        endcase
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_mvalid || m_axis_tready)) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_mvalid || m_axis_tready)) begin
            r_out_int <= r_dis ? r_nom : out_rnd[F+15:F];
            r_out_lvl <= r_dis ? 17'd0 : r_lvl;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {7'd0, r_out_lvl, r_out_int};

    `SAP_ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, r_state != ST_IDLE, "accepted request left block idle")
    `SAP_ASSERT_IMP(a_level_capped, m_axis_tvalid, m_axis_tdata[32:16] <= 17'h10000, "transient level above one")
    `SAP_ASSERT_IMP(a_div_nonzero, div_go, div_den != 24'd0, "divider started with zero divisor")
    `SAP_ASSERT_IMP(a_cur_in_range, r_state == ST_DONE && !r_dis, r_cur >= flo_q && r_cur <= nom_q, "interval outside floor and nominal")

endmodule

@@ tb/tb_slew_adaptive_poll_interval.sv @@
// Testbench for the adaptive poll interval block: directed table and random ticks vs predictor.
module tb_slew_adaptive_poll_interval;
    import sap_pkg::*;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [15:0] cpu_temp;
        logic        cpu_present;
        logic [15:0] gpu_temp;
        logic        gpu_present;
        logic [15:0] elapsed_ms;
        bit          has_known;
        logic [15:0] known_interval;
        logic [16:0] known_level;
    } t_tick;

    typedef struct {
        logic [15:0] interval_ms;
        logic [16:0] level;
    } t_poll;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [15:0] cpu_temp, [31:16] gpu_temp, [47:32] elapsed_ms
    logic [47:0] s_axis_tdata;
    // [0] cpu_present, [1] gpu_present
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [15:0] interval_ms, [32:16] transient_level, [39:33] zero
    logic [39:0] m_axis_tdata;

    slew_adaptive_poll_interval dut (.*);

    // predictor copy of registers and history
    logic [15:0] cfg_nominal, cfg_floor;
    logic [23:0] cfg_start, cfg_full, cfg_relax;
    logic [15:0] hist_cpu, hist_gpu;
    bit          hist_cpu_ok, hist_gpu_ok, working_ok;
    longint unsigned working_q;

    t_poll  pending_polls[$];
    t_tick  directed[$];
    int     errors = 0;
    int     sender_idle_pct = 0;
    int     receiver_stall_pct = 0;
    bit     hold_off = 0;
    int     quiet_cycles = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned rnd_q16(longint unsigned v);
        return (v + 32768) >> 16;
    endfunction

    function automatic longint unsigned slew_between(logic [15:0] now, logic [15:0] was,
                                                     logic [15:0] ms);
        longint signed d;
        longint unsigned s;
        d = longint'($signed(now)) - longint'($signed(was));
        if (d < 0) d = -d;
        s = (longint'(d) * 1000) / ms;
        return (s > 64'hFFFFFF) ? 64'hFFFFFF : s;
    endfunction

    function automatic longint unsigned smoothstep_level(longint unsigned slew);
        longint unsigned a, a2, a3, q, s;
        if (cfg_full <= cfg_start || slew <= cfg_start) return 0;
        if (slew >= cfg_full) return 65536;
        a = ((slew - cfg_start) << 16) / (cfg_full - cfg_start);
        if (a > 65536) a = 65536;
        a2 = rnd_q16(a * a);
        a3 = rnd_q16(a2 * a);
        q = rnd_q16(6 * a * a + (64'd10 << 32) - 15 * (a << 16));
        s = rnd_q16(a3 * q);
        return (s > 65536) ? 65536 : s;
    endfunction

    function automatic t_poll predict_poll(t_tick t);
        t_poll r;
        longint unsigned nom, flo, nom_q, flo_q, slew, lvl, tgt_q, cur, gap, x, allowed;
        nom = cfg_nominal;
        flo = cfg_floor;
        nom_q = nom << FRAC;
        flo_q = flo << FRAC;
        lvl = 0;
        if (flo >= nom) begin
            r.interval_ms = nom[15:0];
            r.level = 0;
            return r;
        end
        if (!working_ok) begin
            working_q = nom_q;
            working_ok = 1;
        end
        if (t.elapsed_ms != 0) begin
            slew = 0;
            if (t.cpu_present && hist_cpu_ok)
                slew = slew_between(t.cpu_temp, hist_cpu, t.elapsed_ms);
            if (t.gpu_present && hist_gpu_ok) begin
                x = slew_between(t.gpu_temp, hist_gpu, t.elapsed_ms);
                if (x > slew) slew = x;
            end
            lvl = smoothstep_level(slew);
        end
        hist_cpu_ok = t.cpu_present;
        hist_cpu = t.cpu_present ? t.cpu_temp : 16'h0;
        hist_gpu_ok = t.gpu_present;
        hist_gpu = t.gpu_present ? t.gpu_temp : 16'h0;
        tgt_q = (((nom << 16) - lvl * (nom - flo) + 32768) >> 16) << FRAC;
        cur = working_q;
        if (t.elapsed_ms == 0 || tgt_q <= cur || cfg_relax == 0) begin
            cur = tgt_q;
        end else begin
            gap = tgt_q - cur;
            x = longint'(cfg_relax) * t.elapsed_ms;
            allowed = ((x / 256000) << FRAC) + (((x % 256000) << FRAC) / 256000);
            if (gap <= ((64'd1 << FRAC) / 10000) || gap <= allowed) cur = tgt_q;
            else cur = cur + allowed;
        end
        if (cur < flo_q) cur = flo_q;
        if (cur > nom_q) cur = nom_q;
        working_q = cur;
        r.interval_ms = 16'((cur + (64'd1 << (FRAC - 1))) >> FRAC);
        r.level = 17'(lvl);
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_NOMINAL: cfg_nominal = value[15:0];
            REG_FLOOR:   cfg_floor = value[15:0];
            REG_START:   cfg_start = value[23:0];
            REG_FULL:    cfg_full = value[23:0];
            REG_RELAX:   cfg_relax = value[23:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] nom, logic [15:0] flo, logic [23:0] st,
                              logic [23:0] fu, logic [23:0] rl);
        write_reg(REG_NOMINAL, nom);
        write_reg(REG_FLOOR, flo);
        write_reg(REG_START, st);
        write_reg(REG_FULL, fu);
        write_reg(REG_RELAX, rl);
    endtask

    // waits until the block has returned every result, then a latency margin
    task automatic drain;
        while (pending_polls.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic send_tick(t_tick t);
        t_poll exp_poll;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {t.elapsed_ms, t.gpu_temp, t.cpu_temp};
        s_axis_tuser <= {t.gpu_present, t.cpu_present};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_poll = predict_poll(t);
        if (t.has_known) begin
            exp_poll.interval_ms = t.known_interval;
            exp_poll.level = t.known_level;
        end
        pending_polls.push_back(exp_poll);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    function automatic t_tick random_tick(int span);
        t_tick t;
        int base;
        base = $urandom_range(4000) - 2000;
        t.cpu_present = ($urandom_range(9) != 0);
        t.gpu_present = ($urandom_range(9) != 0);
        if ($urandom_range(9) < 7) begin
            t.cpu_temp = 16'(base + int'($urandom_range(2 * span)) - span);
            t.gpu_temp = 16'(base + int'($urandom_range(2 * span)) - span);
        end else begin
            t.cpu_temp = 16'($urandom);
            t.gpu_temp = 16'($urandom);
        end
        case ($urandom_range(9))
            0: t.elapsed_ms = 0;
            1: t.elapsed_ms = 16'($urandom);
            2: t.elapsed_ms = 16'hFFFF;
            default: t.elapsed_ms = 16'($urandom_range(2000, 1));
        endcase
        t.has_known = 0;
        return t;
    endfunction

    function automatic t_tick mk(logic [15:0] c, logic cp, logic [15:0] g, logic gp,
                                 logic [15:0] ms);
        t_tick t;
        t.cpu_temp = c; t.cpu_present = cp; t.gpu_temp = g; t.gpu_present = gp;
        t.elapsed_ms = ms; t.has_known = 0;
        return t;
    endfunction

    function automatic t_tick mk_known(t_tick t, logic [15:0] ivl, logic [16:0] lvl);
        t.has_known = 1; t.known_interval = ivl; t.known_level = lvl;
        return t;
    endfunction

    // receiver: stall at random, or hold off for a long stretch when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 0;
        else if (hold_off) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_poll exp_poll;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_polls.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp_poll = pending_polls.pop_front();
                if (m_axis_tdata[15:0] !== exp_poll.interval_ms) begin
                    $display("%0t interval_ms expected %0d got %0d", $time,
                             exp_poll.interval_ms, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[32:16] !== exp_poll.level) begin
                    $display("%0t transient_level expected %0d got %0d", $time,
                             exp_poll.level, m_axis_tdata[32:16]);
                    errors++;
                end
                if (m_axis_tdata[39:33] !== 7'd0) begin
                    $display("%0t pad expected 0 got %h", $time, m_axis_tdata[39:33]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int span;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        m_axis_tready = 0;
        cfg_nominal = 1000; cfg_floor = 1000; cfg_start = 256; cfg_full = 1280;
        cfg_relax = 25600;
        hist_cpu = 0; hist_gpu = 0; hist_cpu_ok = 0; hist_gpu_ok = 0;
        working_ok = 0; working_q = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // after reset adaptation is off: nominal, level zero
        directed.push_back(mk_known(mk(16'h7FFF, 1, 16'h8000, 1, 16'hFFFF), 16'd1000, 17'd0));
        directed.push_back(mk_known(mk(16'h8000, 1, 16'h7FFF, 1, 16'd1), 16'd1000, 17'd0));
        foreach (directed[i]) send_tick(directed[i]);
        drain();
        directed.delete();

        set_config(16'd1000, 16'd100, 24'd256, 24'd1280, 24'd25600);
        directed.push_back(mk(16'd0, 1, 16'd0, 1, 16'd1000));
        // huge slew saturates: full level
        directed.push_back(mk_known(mk(16'h7FFF, 1, 16'h0, 1, 16'd1), 16'd100, 17'd65536));
        directed.push_back(mk_known(mk(16'h8000, 1, 16'h0, 1, 16'd1), 16'd100, 17'd65536));
        directed.push_back(mk(16'h8000, 1, 16'h0100, 1, 16'd1000));
        directed.push_back(mk(16'h8100, 1, 16'h0200, 1, 16'd1000));
        directed.push_back(mk(16'h8100, 0, 16'h0300, 1, 16'd1000));
        directed.push_back(mk(16'h9000, 1, 16'h0300, 0, 16'd1000));
        directed.push_back(mk(16'h9000, 1, 16'h0300, 1, 16'd0));
        directed.push_back(mk(16'h9400, 1, 16'h0300, 1, 16'd0));
        directed.push_back(mk(16'h9400, 1, 16'h0300, 1, 16'hFFFF));
        directed.push_back(mk(16'h9500, 1, 16'h0380, 1, 16'd1000));
        directed.push_back(mk(16'h0, 0, 16'h0, 0, 16'd500));
        foreach (directed[i]) send_tick(directed[i]);
        drain();

        // inverted thresholds, zero relax, extremes
        set_config(16'hFFFF, 16'd0, 24'hFFFFFF, 24'd0, 24'd0);
        for (int i = 0; i < 6; i++) send_tick(random_tick(2000));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
                3: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
            endcase
            case (phase)
                0: set_config(16'd1000, 16'd100, 24'd256, 24'd1280, 24'd25600);
                1: set_config(16'hFFFF, 16'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
                2: set_config(16'd1, 16'd0, 24'd100, 24'd50000, 24'd1);
                3: set_config(16'd5000, 16'd5000, 24'd256, 24'd1280, 24'd25600);
                4: set_config(16'd2000, 16'd10, 24'd0, 24'd3000, 24'd0);
                5: set_config(16'($urandom_range(65535, 2)), 16'($urandom_range(1000)),
                              24'($urandom_range(5000)), 24'($urandom_range(200000)),
                              24'($urandom));
                6: set_config(16'd30000, 16'd20, 24'd1000, 24'd1000, 24'd512);
                7: set_config(16'd800, 16'd50, 24'd128, 24'd6000, 24'd2560000);
            endcase
            if (phase == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            span = (phase % 2) ? 4000 : 300;
            for (int i = 0; i < 150; i++) send_tick(random_tick(span));
            drain();
        end

        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
